FILE: rtl/pbr_pkg.sv
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared types and constants for the phase-bit ring pipe bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbr_pkg;

  // Bank geometry. PipeDepth must be a power of two: a pointer is then the
  // word index with the wrap phase as its top bit, and +1 handles the wrap.
  localparam int PipeCount = 16;
  localparam int PipeDepth = 256;

  localparam int PipeW  = $clog2(PipeCount);
  localparam int IdxW   = $clog2(PipeDepth);
  localparam int PtrW   = IdxW + 1;
  localparam int AddrW  = PipeW + IdxW;
  localparam int WordW  = 16;
  localparam int LvlW   = 9;
  localparam int LvlMax = (1 << LvlW) - 1;

  // Command codes
  localparam logic [1:0] CmdQuery = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdWrite = 2'd2;

  // Status codes
  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  pipe_index;
    logic [15:0] write_data;
    logic        burst_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [8:0]  level_words;
    logic [1:0]  status;
    logic        notify;
    logic [3:0]  notify_pipe;
  } out_item_t;

  // Read and write pointer of one pipe
  typedef struct packed {
    logic [PtrW-1:0] rd_ptr;
    logic [PtrW-1:0] wr_ptr;
  } ptr_pair_t;

  // Request to the pointer table
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [PipeW-1:0] addr;
    ptr_pair_t        wr_data;
  } ptr_req_t;

  // Request to the word memory
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] wr_data;
  } word_req_t;

endpackage

FILE: rtl/pbr_ptr_table.sv
// ----------------------------------------------------------------------------
// pbr_ptr_table
// Per-pipe pointer memory, one read or write port, registered read data.
// Entries not yet written since reset read as zero (valid bit per entry).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbr_ptr_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbr_pkg::ptr_req_t   req_i,
  output pbr_pkg::ptr_pair_t  rd_data_o
);

  pbr_pkg::ptr_pair_t             mem_q [pbr_pkg::PipeCount];
  logic [pbr_pkg::PipeCount-1:0]  valid_q;
  pbr_pkg::ptr_pair_t             rd_q;
  logic                           rd_vld_q;

  // Storage array
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.addr];
    end
  end

  // Valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: rtl/pbr_word_ram.sv
// ----------------------------------------------------------------------------
// pbr_word_ram
// Word storage for all pipes, single port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbr_word_ram (
  input  logic                       clk_i,
  input  pbr_pkg::word_req_t         req_i,
  output logic [pbr_pkg::WordW-1:0]  rd_data_o
);

  localparam int Depth = pbr_pkg::PipeCount * pbr_pkg::PipeDepth;

  logic [pbr_pkg::WordW-1:0] mem_q [Depth];
  logic [pbr_pkg::WordW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: rtl/phase_bit_ring_pipes.sv
// ----------------------------------------------------------------------------
// phase_bit_ring_pipes
// Bank of circular word pipes with wrap phase bits on each pointer.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  in_data_i   (pbr_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i out_data_o (pbr_pkg::out_item_t)
//
// One transaction at a time: pointer table read, pointer update (plus word
// write), word read for a read command, then the result register.
// A query or write result goes from the pointer step to the result step, a
// read through the word read step first (extra word memory access); a new
// transaction is taken only after the sequencer returns to idle.
// Reset clears the pointer valid bits at once; no clearing pass is needed.
// A stalled result holds the sequencer in its result step until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phase_bit_ring_pipes (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pbr_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pbr_pkg::out_item_t  out_data_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPtr  = 2'd1;
  localparam logic [1:0] StData = 2'd2;
  localparam logic [1:0] StRes  = 2'd3;

  logic [1:0]          state_q, state_d;
  pbr_pkg::in_item_t   item_q;
  pbr_pkg::out_item_t  res_q, res_d;
  pbr_pkg::out_item_t  out_q;
  logic                out_valid_q, out_valid_d;

  pbr_pkg::ptr_req_t   ptr_req;
  pbr_pkg::ptr_pair_t  ptr_rd;
  pbr_pkg::word_req_t  word_req;
  logic [pbr_pkg::WordW-1:0] word_rd;

  logic                    in_acc;
  logic                    out_free;
  logic                    in_range;
  logic [pbr_pkg::PtrW-1:0] lvl_now, lvl_new;
  logic                    is_empty, is_full, rd_ok, wr_ok;
  pbr_pkg::ptr_pair_t      ptr_new;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Memories
  pbr_ptr_table u_ptr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ptr_req),
    .rd_data_o (ptr_rd)
  );

  pbr_word_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (word_req),
    .rd_data_o (word_rd)
  );

  // Decision on the fetched pointers
  always_comb begin
    in_range = (32'(item_q.pipe_index) < pbr_pkg::PipeCount);
    lvl_now  = ptr_rd.wr_ptr - ptr_rd.rd_ptr;
    is_empty = (ptr_rd.wr_ptr == ptr_rd.rd_ptr);
    is_full  = (32'(lvl_now) >= pbr_pkg::PipeDepth);
    rd_ok    = in_range && (item_q.cmd == pbr_pkg::CmdRead) && !is_empty;
    wr_ok    = in_range && (item_q.cmd == pbr_pkg::CmdWrite) && !is_full;
    ptr_new  = ptr_rd;
    if (rd_ok) begin
      ptr_new.rd_ptr = ptr_rd.rd_ptr + 1'b1;
    end
    if (wr_ok) begin
      ptr_new.wr_ptr = ptr_rd.wr_ptr + 1'b1;
    end
    lvl_new = ptr_new.wr_ptr - ptr_new.rd_ptr;
  end

  // Memory requests
  always_comb begin
    ptr_req          = '0;
    ptr_req.addr     = item_q.pipe_index[pbr_pkg::PipeW-1:0];
    ptr_req.wr_data  = ptr_new;
    word_req         = '0;
    word_req.wr_data = item_q.write_data;
    word_req.addr    = {item_q.pipe_index[pbr_pkg::PipeW-1:0],
                        ptr_rd.wr_ptr[pbr_pkg::IdxW-1:0]};
    if (in_acc) begin
      ptr_req.rd_en = 1'b1;
      ptr_req.addr  = in_data_i.pipe_index[pbr_pkg::PipeW-1:0];
    end
    if (state_q == StPtr) begin
      ptr_req.wr_en  = rd_ok || wr_ok;
      word_req.wr_en = wr_ok;
      word_req.rd_en = rd_ok;
      if (rd_ok) begin
        word_req.addr = {item_q.pipe_index[pbr_pkg::PipeW-1:0],
                         ptr_rd.rd_ptr[pbr_pkg::IdxW-1:0]};
      end
    end
  end

  // Sequencer and result assembly
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StPtr;
        end
      end
      StPtr: begin
        res_d = '0;
        if (in_range) begin
          if (32'(lvl_new) > pbr_pkg::LvlMax) begin
            res_d.level_words = pbr_pkg::LvlW'(pbr_pkg::LvlMax);
          end else begin
            res_d.level_words = pbr_pkg::LvlW'(lvl_new);
          end
          if (item_q.cmd == pbr_pkg::CmdRead || item_q.cmd == pbr_pkg::CmdWrite) begin
            res_d.notify = item_q.burst_end;
            if (item_q.burst_end) begin
              res_d.notify_pipe = item_q.pipe_index;
            end
          end
          if (item_q.cmd == pbr_pkg::CmdRead && is_empty) begin
            res_d.status = pbr_pkg::StatusEmpty;
          end
          if (item_q.cmd == pbr_pkg::CmdWrite && is_full) begin
            res_d.status = pbr_pkg::StatusFull;
          end
        end
        state_d = rd_ok ? StData : StRes;
      end
      StData: begin
        res_d.read_data = word_rd;
        state_d         = StRes;
      end
      StRes: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    res_q <= res_d;
    if (state_q == StRes && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_accept_to_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == StPtr)
    else $error("accepted transaction did not enter pointer step");

  a_data_after_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StData |-> $past(state_q) == StPtr)
    else $error("word read step without pointer step");

  a_word_write_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_req.wr_en |-> state_q == StPtr && !is_full)
    else $error("word write outside pointer step or on a full pipe");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StPtr |-> 32'(lvl_now) <= pbr_pkg::PipeDepth)
    else $error("pipe level beyond its depth");

  a_refused_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != pbr_pkg::StatusDone |-> out_data_o.read_data == '0)
    else $error("refused transaction returned data");

endmodule
